// ----- sv/stx_etx_response_receiver_top_defines.svh -----
// assertion macros shared by the checker of the frame receiver
`ifndef STX_ETX_RESPONSE_RECEIVER_TOP_DEFINES_SVH
`define STX_ETX_RESPONSE_RECEIVER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ERX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("erx assertion failed");

// next-cycle implication, disabled in reset
`define ERX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("erx assertion failed");

`endif

// ----- sv/erx_pkg.sv -----
// shared types, byte codes and constants of the stx/etx frame receiver
package erx_pkg;

    localparam int MAX_BODY_DEF = 512;
    localparam int CNT_W        = 10;
    localparam int QDEPTH       = 2;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_CMD_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_RECOVERY_EN = 2'd2;

    localparam logic [7:0] B_STX     = 8'h02;
    localparam logic [7:0] B_ETX     = 8'h03;
    localparam logic [7:0] B_ACK     = 8'h06;
    localparam logic [7:0] B_DC2     = 8'h12;
    localparam logic [7:0] B_DC4     = 8'h14;
    localparam logic [7:0] B_NAK     = 8'h15;
    localparam logic [7:0] B_ANOMALY = 8'h7F;

    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_BODY      = 4'd1;
    localparam logic [3:0] KIND_DISCARDED = 4'd2;
    localparam logic [3:0] KIND_BUSY      = 4'd3;
    localparam logic [3:0] KIND_PAPER_OUT = 4'd4;
    localparam logic [3:0] KIND_GOOD      = 4'd5;
    localparam logic [3:0] KIND_BAD       = 4'd6;
    localparam logic [3:0] KIND_ANOMALY   = 4'd7;
    localparam logic [3:0] KIND_EXHAUSTED = 4'd8;
    localparam logic [3:0] KIND_TIMEOUT   = 4'd9;

    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_DC2,
        CLS_DC4,
        CLS_IGNORE,
        CLS_STX,
        CLS_ETX
    } t_cls;

    typedef struct packed {
        logic [1:0] action;
        logic       wait_for_start;
        logic       clear_busy;
        logic [7:0] rx_byte;
        t_cls       cls;
        logic [3:0] nibble;
        logic       hex_bad;
    } t_qword;

    typedef struct packed {
        logic   push;
        t_qword word;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_qword word;
    } t_head;

endpackage

// ----- sv/erx_front.sv -----
// front end: takes input words, classifies the received byte and decodes it as a checksum digit
module erx_front (
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic             i_wait_for_start,
    input  logic             i_clear_busy_count,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_q_full,
    output erx_pkg::t_push   o_push
);
    import erx_pkg::*;

    t_cls       cls;
    logic [3:0] nib;
    logic       bad;

    always_comb begin
        case (i_rx_byte)
            B_DC2:        cls = CLS_DC2;
            B_DC4:        cls = CLS_DC4;
            B_ACK, B_NAK: cls = CLS_IGNORE;
            B_STX:        cls = CLS_STX;
            B_ETX:        cls = CLS_ETX;
            default:      cls = CLS_DATA;
        endcase
    end

    // checksum digit decode, upper and lower case
    always_comb begin
        nib = 4'd0;
        bad = 1'b0;
        if (i_rx_byte >= 8'h30 && i_rx_byte <= 8'h39) begin
            nib = 4'(i_rx_byte - 8'h30);
        end else if (i_rx_byte >= 8'h41 && i_rx_byte <= 8'h46) begin
            nib = 4'(i_rx_byte - 8'h37);
        end else if (i_rx_byte >= 8'h61 && i_rx_byte <= 8'h66) begin
            nib = 4'(i_rx_byte - 8'h57);
        end else begin
            bad = 1'b1;
        end
    end

    assign o_in_ready = !i_q_full;

    always_comb begin
        o_push.push                = i_in_valid && !i_q_full;
        o_push.word.action         = i_action;
        o_push.word.wait_for_start = i_wait_for_start;
        o_push.word.clear_busy     = i_clear_busy_count;
        o_push.word.rx_byte        = i_rx_byte;
        o_push.word.cls            = cls;
        o_push.word.nibble         = nib;
        o_push.word.hex_bad        = bad;
    end

endmodule

// ----- sv/erx_queue.sv -----
// short queue of classified words between front and back end
module erx_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  erx_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output erx_pkg::t_head o_head
);
    import erx_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_qword              r_mem [QDEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_QW-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_QW'(QDEPTH));
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/erx_back.sv -----
// back end: frame state machine, checksum, retries and result register
module erx_back #(
    parameter int MAX_BODY = erx_pkg::MAX_BODY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_cfg_retry_limit,
    input  logic [1:0]                i_cfg_cmd_offset,
    input  logic                      i_cfg_recovery_en,
    input  erx_pkg::t_head            i_head,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [3:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic                      o_send_ack,
    output logic                      o_send_nak,
    output logic                      o_send_recovery,
    output logic [7:0]                o_packet_number,
    output logic [7:0]                o_command_code,
    output logic [erx_pkg::CNT_W-1:0] o_body_length,
    output logic [7:0]                o_retries_left,
    output logic [15:0]               o_busy_count
);
    import erx_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_STX   = 4'b0010,
        PH_BODY  = 4'b0100,
        PH_CHECK = 4'b1000
    } t_phase;

    t_phase           r_phase,     n_phase;
    logic [CNT_W-1:0] r_body_cnt,  n_body_cnt;
    logic [15:0]      r_body_sum,  n_body_sum;
    logic [15:0]      r_chk_val,   n_chk_val;
    logic [2:0]       r_chk_dig,   n_chk_dig;
    logic             r_chk_bad,   n_chk_bad;
    logic [7:0]       r_retry,     n_retry;
    logic [7:0]       r_first,     n_first;
    logic [7:0]       r_cmd,       n_cmd;
    logic [15:0]      r_busy,      n_busy;
    logic             r_out_valid;

    logic [3:0]  kind;
    logic [7:0]  data;
    logic        ack, nak, rec;
    logic [7:0]  pkt, cmd;
    logic [7:0]  retry_dec;
    logic        retry_out;
    logic [15:0] chk_next;
    logic [2:0]  dig_next;
    logic        bad_next;
    logic [15:0] calc;
    logic        fire;
    t_qword      w;

    assign w    = i_head.word;
    assign fire = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop = fire;

    assign retry_dec = (r_retry != 8'd0) ? r_retry - 8'd1 : 8'd0;
    assign retry_out = (retry_dec == 8'd0);
    assign chk_next  = {r_chk_val[11:0], w.nibble};
    assign dig_next  = r_chk_dig + 3'd1;
    assign bad_next  = r_chk_bad | w.hex_bad;
    assign calc      = r_body_sum + 16'(B_STX) + 16'(B_ETX);

    always_comb begin
        n_phase    = r_phase;
        n_body_cnt = r_body_cnt;
        n_body_sum = r_body_sum;
        n_chk_val  = r_chk_val;
        n_chk_dig  = r_chk_dig;
        n_chk_bad  = r_chk_bad;
        n_retry    = r_retry;
        n_first    = r_first;
        n_cmd      = r_cmd;
        n_busy     = r_busy;
        kind = KIND_NONE;
        data = 8'd0;
        ack  = 1'b0;
        nak  = 1'b0;
        rec  = 1'b0;
        pkt  = 8'd0;
        cmd  = 8'd0;
        case (w.action)
            ACT_START: begin
                if (w.clear_busy) begin
                    n_busy = 16'd0;
                end
                n_body_cnt = '0;
                n_body_sum = 16'd0;
                n_first    = 8'd0;
                n_cmd      = 8'd0;
                n_chk_val  = 16'd0;
                n_chk_dig  = 3'd0;
                n_chk_bad  = 1'b0;
                n_retry    = i_cfg_retry_limit;
                n_phase    = w.wait_for_start ? PH_STX : PH_BODY;
                if (i_cfg_retry_limit == 8'd0) begin
                    n_phase = PH_IDLE;
                    kind    = KIND_EXHAUSTED;
                end
            end
            ACT_TIMEOUT: begin
                if (r_phase != PH_IDLE) begin
                    rec     = i_cfg_recovery_en;
                    n_retry = retry_dec;
                    if (retry_out) begin
                        n_phase = PH_IDLE;
                        kind    = KIND_EXHAUSTED;
                    end else begin
                        kind = KIND_TIMEOUT;
                    end
                end
            end
            ACT_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    case (w.cls)
                        CLS_DC2: begin
                            if (r_busy != 16'hFFFF) begin
                                n_busy = r_busy + 16'd1;
                            end
                            kind = KIND_BUSY;
                        end
                        CLS_DC4: begin
                            kind = KIND_PAPER_OUT;
                        end
                        CLS_IGNORE: begin
                            kind = KIND_NONE;
                        end
                        CLS_STX: begin
                            if (r_phase != PH_STX) begin
                                kind = KIND_DISCARDED;
                            end
                            n_body_cnt = '0;
                            n_body_sum = 16'd0;
                            n_first    = 8'd0;
                            n_cmd      = 8'd0;
                            n_chk_val  = 16'd0;
                            n_chk_dig  = 3'd0;
                            n_chk_bad  = 1'b0;
                            n_phase    = PH_BODY;
                        end
                        CLS_ETX: begin
                            n_chk_val = 16'd0;
                            n_chk_dig = 3'd0;
                            n_chk_bad = 1'b0;
                            if (r_phase == PH_BODY) begin
                                n_phase = PH_CHECK;
                            end else begin
                                if (r_phase == PH_CHECK) begin
                                    kind = KIND_DISCARDED;
                                end
                                n_body_cnt = '0;
                                n_body_sum = 16'd0;
                                n_first    = 8'd0;
                                n_cmd      = 8'd0;
                                n_phase    = PH_STX;
                            end
                        end
                        CLS_DATA: begin
                            if (r_phase == PH_BODY) begin
                                if (r_body_cnt >= CNT_W'(MAX_BODY)) begin
                                    // overflow: drop body; go idle on last retry
                                    n_body_cnt = '0;
                                    n_body_sum = 16'd0;
                                    n_first    = 8'd0;
                                    n_cmd      = 8'd0;
                                    n_retry    = retry_dec;
                                    if (retry_out) begin
                                        n_phase = PH_IDLE;
                                        kind    = KIND_EXHAUSTED;
                                    end else begin
                                        kind = KIND_DISCARDED;
                                    end
                                end else begin
                                    if (r_body_cnt == '0) begin
                                        n_first = w.rx_byte;
                                    end
                                    if (r_body_cnt == CNT_W'(i_cfg_cmd_offset)) begin
                                        n_cmd = w.rx_byte;
                                    end
                                    n_body_cnt = r_body_cnt + 1'b1;
                                    n_body_sum = r_body_sum + 16'(w.rx_byte);
                                    kind = KIND_BODY;
                                    data = w.rx_byte;
                                end
                            end else if (r_phase == PH_CHECK) begin
                                n_chk_val = chk_next;
                                n_chk_dig = dig_next;
                                n_chk_bad = bad_next;
                                if (dig_next >= 3'd4) begin
                                    if (!bad_next && calc == chk_next) begin
                                        ack = 1'b1;
                                        pkt = (r_body_cnt != '0) ? r_first : 8'd0;
                                        cmd = (r_body_cnt > CNT_W'(i_cfg_cmd_offset)) ?
                                              r_cmd : 8'd0;
                                        kind = (pkt == B_ANOMALY) ? KIND_ANOMALY : KIND_GOOD;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        nak     = 1'b1;
                                        n_retry = retry_dec;
                                        if (retry_out) begin
                                            n_phase = PH_IDLE;
                                            kind    = KIND_EXHAUSTED;
                                        end else begin
                                            n_phase = PH_STX;
                                            kind    = KIND_BAD;
                                        end
                                    end
                                    n_chk_val = 16'd0;
                                    n_chk_dig = 3'd0;
                                    n_chk_bad = 1'b0;
                                end
                            end
                        end
                        default: begin
                            kind = KIND_NONE;
                        end
                    endcase
                end
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_body_cnt  <= '0;
            r_body_sum  <= 16'd0;
            r_chk_val   <= 16'd0;
            r_chk_dig   <= 3'd0;
            r_chk_bad   <= 1'b0;
            r_retry     <= 8'd0;
            r_first     <= 8'd0;
            r_cmd       <= 8'd0;
            r_busy      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase    <= n_phase;
                r_body_cnt <= n_body_cnt;
                r_body_sum <= n_body_sum;
                r_chk_val  <= n_chk_val;
                r_chk_dig  <= n_chk_dig;
                r_chk_bad  <= n_chk_bad;
                r_retry    <= n_retry;
                r_first    <= n_first;
                r_cmd      <= n_cmd;
                r_busy     <= n_busy;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded as the word is carried out
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_kind          <= kind;
            o_data_byte     <= data;
            o_send_ack      <= ack;
            o_send_nak      <= nak;
            o_send_recovery <= rec;
            o_packet_number <= pkt;
            o_command_code  <= cmd;
            o_body_length   <= n_body_cnt;
            o_retries_left  <= n_retry;
            o_busy_count    <= n_busy;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/stx_etx_response_receiver_top.sv -----
// top level of the stx/etx response frame receiver
//
//  channel  valid / ready             payload
//  in       i_in_valid / o_in_ready   i_action, i_wait_for_start, i_clear_busy_count, i_rx_byte
//  out      o_out_valid / i_out_ready o_kind .. o_busy_count, one result per input word
//  cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word per cycle sustained while results are taken; the back end handles a whole word as it pops it
// from input to result a word passes through the queue and then the result register
// a two-word queue lets the front keep taking words while a result waits to be taken
// reset is synchronous and active low; there is no clearing pass after it
// configuration is taken every cycle and is meant to change only while idle
module stx_etx_response_receiver_top #(
    parameter int MAX_BODY = erx_pkg::MAX_BODY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_action,
    input  logic                      i_wait_for_start,
    input  logic                      i_clear_busy_count,
    input  logic [7:0]                i_rx_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [3:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic                      o_send_ack,
    output logic                      o_send_nak,
    output logic                      o_send_recovery,
    output logic [7:0]                o_packet_number,
    output logic [7:0]                o_command_code,
    output logic [erx_pkg::CNT_W-1:0] o_body_length,
    output logic [7:0]                o_retries_left,
    output logic [15:0]               o_busy_count,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [7:0]                i_cfg_data
);
    import erx_pkg::*;

    logic [7:0] r_retry_limit;
    logic [1:0] r_cmd_offset;
    logic       r_recovery_en;
    t_push      push;
    t_head      head;
    logic       q_full;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= 8'd3;
            r_cmd_offset  <= 2'd1;
            r_recovery_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data;
                CFG_CMD_OFFSET:  r_cmd_offset  <= i_cfg_data[1:0];
                CFG_RECOVERY_EN: r_recovery_en <= i_cfg_data[0];
                default: begin
                    // unused register index, write dropped
                end
            endcase
        end
    end

    erx_front u_front (
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_wait_for_start   (i_wait_for_start),
        .i_clear_busy_count (i_clear_busy_count),
        .i_rx_byte          (i_rx_byte),
        .i_q_full           (q_full),
        .o_push             (push)
    );

    erx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    erx_back #(
        .MAX_BODY (MAX_BODY)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_retry_limit (r_retry_limit),
        .i_cfg_cmd_offset  (r_cmd_offset),
        .i_cfg_recovery_en (r_recovery_en),
        .i_head            (head),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_send_ack        (o_send_ack),
        .o_send_nak        (o_send_nak),
        .o_send_recovery   (o_send_recovery),
        .o_packet_number   (o_packet_number),
        .o_command_code    (o_command_code),
        .o_body_length     (o_body_length),
        .o_retries_left    (o_retries_left),
        .o_busy_count      (o_busy_count)
    );

endmodule

// ----- sv/erx_checker.sv -----
// port-level checker of the frame receiver and its bind
`include "stx_etx_response_receiver_top_defines.svh"

module erx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic        o_send_ack,
    input logic        o_send_nak,
    input logic        o_send_recovery,
    input logic [7:0]  o_packet_number
);
    import erx_pkg::*;

    // a result that is held back keeps its word
    `ERX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_data_byte))

    // ack only on a frame that checked out
    `ERX_ASSERT_NOW(a_ack_kind, i_clk, i_rst_n, o_out_valid && o_send_ack, o_kind == KIND_GOOD || o_kind == KIND_ANOMALY)

    // nak only on a failed checksum, possibly the last retry
    `ERX_ASSERT_NOW(a_nak_kind, i_clk, i_rst_n, o_out_valid && o_send_nak, o_kind == KIND_BAD || o_kind == KIND_EXHAUSTED)

    // anomaly frames carry the reserved packet number
    `ERX_ASSERT_NOW(a_anomaly_pkt, i_clk, i_rst_n, o_out_valid && o_kind == KIND_ANOMALY, o_packet_number == B_ANOMALY)

    // recovery request only on a timeout outcome
    `ERX_ASSERT_NOW(a_rec_kind, i_clk, i_rst_n, o_out_valid && o_send_recovery, o_kind == KIND_TIMEOUT || o_kind == KIND_EXHAUSTED)

endmodule

bind stx_etx_response_receiver_top erx_checker u_erx_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for the stx/etx response receiver: frames, noise and timeouts vs a predictor
module tb_top;
    import erx_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int BODY_LIMIT  = MAX_BODY_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 8;

    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam int FLAW_NONE   = 0;
    localparam int FLAW_WRONG  = 1;
    localparam int FLAW_NONHEX = 2;
    localparam int FLAW_ETX    = 3;
    localparam int FLAW_SHORT  = 4;

    typedef enum bit [1:0] {ST_IDLE, ST_WAIT_STX, ST_BODY, ST_CHECK} rx_state_e;

    typedef struct packed {
        logic [1:0] action;
        logic       wait_for_start;
        logic       clear_busy;
        logic [7:0] rx_byte;
    } rx_word_t;

    typedef struct packed {
        logic [3:0]       kind;
        logic [7:0]       data;
        logic             ack;
        logic             nak;
        logic             recovery;
        logic [7:0]       packet;
        logic [7:0]       command;
        logic [CNT_W-1:0] length;
        logic [7:0]       retries;
        logic [15:0]      busy;
    } rx_result_t;

    class rx_response_tracker;
        bit [7:0]  retry_limit = 8'd3;
        bit [1:0]  cmd_offset  = 2'd1;
        bit        recovery_en = 1'b0;

        rx_state_e state = ST_IDLE;
        bit [9:0]  body_count;
        bit [15:0] body_sum;
        bit [15:0] check_value;
        bit [2:0]  check_digits;
        bit        check_invalid;
        bit [7:0]  retries;
        bit [7:0]  first_byte;
        bit [7:0]  command_byte;
        bit [15:0] busy_events;

        rx_result_t pending_responses[$];
        int errors;
        int reported;

        function void clear_body();
            body_count   = '0;
            body_sum     = '0;
            first_byte   = '0;
            command_byte = '0;
        endfunction

        function void clear_check();
            check_value   = '0;
            check_digits  = '0;
            check_invalid = 1'b0;
        endfunction

        // one retry gone; true when the wait is over
        function bit take_retry();
            if (retries != 0) retries--;
            if (retries == 0) begin
                state = ST_IDLE;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit [3:0] hex_nibble(bit [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
            if (c >= CH_UPPER && c <= CH_UPPER_F) return 4'(c - CH_UPPER + 8'd10);
            if (c >= CH_LOWER && c <= CH_LOWER_F) return 4'(c - CH_LOWER + 8'd10);
            check_invalid = 1'b1;
            return 4'd0;
        endfunction

        function void set_config(logic [1:0] index, logic [7:0] value);
            case (index)
                CFG_RETRY_LIMIT: retry_limit = value;
                CFG_CMD_OFFSET:  cmd_offset  = value[1:0];
                CFG_RECOVERY_EN: recovery_en = value[0];
                default: ;
            endcase
        endfunction

        function rx_result_t next_response(rx_word_t w);
            rx_result_t r;
            bit [15:0]  calc;
            bit [3:0]   nib;
            r = '0;
            case (w.action)
                ACT_START: begin
                    if (w.clear_busy) busy_events = '0;
                    clear_body();
                    clear_check();
                    retries = retry_limit;
                    state = w.wait_for_start ? ST_WAIT_STX : ST_BODY;
                    if (retries == 0) begin
                        state  = ST_IDLE;
                        r.kind = KIND_EXHAUSTED;
                    end
                end
                ACT_TIMEOUT: if (state != ST_IDLE) begin
                    r.recovery = recovery_en;
                    r.kind = take_retry() ? KIND_EXHAUSTED : KIND_TIMEOUT;
                end
                ACT_BYTE: if (state != ST_IDLE) begin
                    if (w.rx_byte == B_DC2) begin
                        if (busy_events != 16'hFFFF) busy_events++;
                        r.kind = KIND_BUSY;
                    end else if (w.rx_byte == B_DC4) begin
                        r.kind = KIND_PAPER_OUT;
                    end else if (w.rx_byte == B_ACK || w.rx_byte == B_NAK) begin
                        r.kind = KIND_NONE;
                    end else if (w.rx_byte == B_STX) begin
                        if (state != ST_WAIT_STX) r.kind = KIND_DISCARDED;
                        clear_body();
                        clear_check();
                        state = ST_BODY;
                    end else if (w.rx_byte == B_ETX) begin
                        if (state == ST_BODY) begin
                            clear_check();
                            state = ST_CHECK;
                        end else begin
                            if (state == ST_CHECK) r.kind = KIND_DISCARDED;
                            clear_body();
                            clear_check();
                            state = ST_WAIT_STX;
                        end
                    end else if (state == ST_BODY) begin
                        if (body_count >= BODY_LIMIT) begin
                            clear_body();
                            r.kind = take_retry() ? KIND_EXHAUSTED : KIND_DISCARDED;
                        end else begin
                            if (body_count == 0) first_byte = w.rx_byte;
                            if (body_count == cmd_offset) command_byte = w.rx_byte;
                            body_count++;
                            body_sum = body_sum + w.rx_byte;
                            r.kind = KIND_BODY;
                            r.data = w.rx_byte;
                        end
                    end else if (state == ST_CHECK) begin
                        nib = hex_nibble(w.rx_byte);
                        check_value = {check_value[11:0], nib};
                        check_digits++;
                        if (check_digits >= 4) begin
                            calc = body_sum + B_STX + B_ETX;
                            if (!check_invalid && calc == check_value) begin
                                r.ack     = 1'b1;
                                r.packet  = (body_count > 0) ? first_byte : 8'd0;
                                r.command = (body_count > cmd_offset) ? command_byte : 8'd0;
                                r.kind    = (r.packet == B_ANOMALY) ? KIND_ANOMALY : KIND_GOOD;
                                state     = ST_IDLE;
                            end else begin
                                r.nak  = 1'b1;
                                state  = ST_WAIT_STX;
                                r.kind = take_retry() ? KIND_EXHAUSTED : KIND_BAD;
                            end
                            clear_check();
                        end
                    end
                end
                default: ;
            endcase
            r.length  = body_count;
            r.retries = retries;
            r.busy    = busy_events;
            return r;
        endfunction

        // true when the word does more than get ignored
        function bit accept_word(rx_word_t w);
            bit live;
            live = (w.action == ACT_START) ||
                   (state != ST_IDLE && (w.action == ACT_BYTE || w.action == ACT_TIMEOUT));
            pending_responses.push_back(next_response(w));
            return live;
        endfunction

        function void cmp(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                if (reported < 50) begin
                    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                    reported++;
                end
            end
        endfunction

        function void match_result(rx_result_t got);
            rx_result_t want;
            if (pending_responses.size() == 0) begin
                errors++;
                if (reported < 50) begin
                    $display("%0t: result with none expected, kind %0h", $time, got.kind);
                    reported++;
                end
                return;
            end
            want = pending_responses.pop_front();
            cmp("kind", want.kind, got.kind);
            cmp("data_byte", want.data, got.data);
            cmp("send_ack", want.ack, got.ack);
            cmp("send_nak", want.nak, got.nak);
            cmp("send_recovery", want.recovery, got.recovery);
            cmp("packet_number", want.packet, got.packet);
            cmp("command_code", want.command, got.command);
            cmp("body_length", want.length, got.length);
            cmp("retries_left", want.retries, got.retries);
            cmp("busy_count", want.busy, got.busy);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_action = '0;
    logic             i_wait_for_start = 1'b0;
    logic             i_clear_busy_count = 1'b0;
    logic [7:0]       i_rx_byte = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [3:0]       o_kind;
    logic [7:0]       o_data_byte;
    logic             o_send_ack;
    logic             o_send_nak;
    logic             o_send_recovery;
    logic [7:0]       o_packet_number;
    logic [7:0]       o_command_code;
    logic [CNT_W-1:0] o_body_length;
    logic [7:0]       o_retries_left;
    logic [15:0]      o_busy_count;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = '0;
    logic [7:0]       i_cfg_data = '0;

    rx_response_tracker tracker;
    rx_result_t         dut_result;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int live_words    = 0;
    int quiet_cycles  = 0;

    stx_etx_response_receiver_top #(
        .MAX_BODY(BODY_LIMIT)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_wait_for_start   (i_wait_for_start),
        .i_clear_busy_count (i_clear_busy_count),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_kind             (o_kind),
        .o_data_byte        (o_data_byte),
        .o_send_ack         (o_send_ack),
        .o_send_nak         (o_send_nak),
        .o_send_recovery    (o_send_recovery),
        .o_packet_number    (o_packet_number),
        .o_command_code     (o_command_code),
        .o_body_length      (o_body_length),
        .o_retries_left     (o_retries_left),
        .o_busy_count       (o_busy_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    assign dut_result = {o_kind, o_data_byte, o_send_ack, o_send_nak, o_send_recovery,
                         o_packet_number, o_command_code, o_body_length, o_retries_left,
                         o_busy_count};

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.match_result(dut_result);
    end

    // ends a run that has stopped moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic rx_word_t mk_word(logic [1:0] act, logic [7:0] b);
        rx_word_t w;
        w.action         = act;
        w.wait_for_start = 1'($urandom_range(0, 1));
        w.clear_busy     = 1'($urandom_range(0, 1));
        w.rx_byte        = b;
        return w;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER && c <= CH_UPPER_F) ||
               (c >= CH_LOWER && c <= CH_LOWER_F);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return CH_ZERO + n;
        return ($urandom_range(0, 1) ? CH_LOWER : CH_UPPER) + n - 8'd10;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == B_STX || b == B_ETX || b == B_ACK || b == B_DC2 || b == B_DC4 ||
               b == B_NAK);
        return b;
    endfunction

    function automatic logic [7:0] pick_control(bit framing);
        case ($urandom_range(0, framing ? 5 : 3))
            0: return B_DC2;
            1: return B_DC4;
            2: return B_ACK;
            3: return B_NAK;
            4: return B_STX;
            default: return B_ETX;
        endcase
    endfunction

    task automatic send_word(rx_word_t w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_action           <= w.action;
        i_wait_for_start   <= w.wait_for_start;
        i_clear_busy_count <= w.clear_busy;
        i_rx_byte          <= w.rx_byte;
        do @(posedge i_clk); while (!o_in_ready);
        if (tracker.accept_word(w)) live_words++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(mk_word(ACT_BYTE, b));
    endtask

    task automatic send_start(bit wfs, bit clr);
        rx_word_t w;
        w = mk_word(ACT_START, 8'($urandom_range(0, 255)));
        w.wait_for_start = wfs;
        w.clear_busy     = clr;
        send_word(w);
    endtask

    task automatic send_checksum(logic [15:0] sum, int flaw);
        logic [15:0] v;
        logic [7:0]  c;
        int          k;
        v = sum + B_STX + B_ETX;
        k = $urandom_range(0, 3);
        if (flaw == FLAW_WRONG) v = v ^ (16'h1 << (4 * k));
        for (int i = 0; i < 4; i++) begin
            if (flaw == FLAW_ETX && i == k) begin
                send_byte(B_ETX);
                return;
            end
            if (flaw == FLAW_NONHEX && i == k) begin
                do c = 8'($urandom_range(32, 126)); while (is_hex(c));
                send_byte(c);
            end else begin
                send_byte(hex_char(v[15 - 4 * i -: 4]));
            end
        end
    endtask

    task automatic send_frame(int len, int flaw, bit anomaly, bit lead_stx);
        logic [15:0] sum;
        logic [7:0]  b;
        sum = '0;
        if (lead_stx) send_byte(B_STX);
        for (int i = 0; i < len; i++) begin
            // printer status words may land anywhere in the body
            if ($urandom_range(0, 19) == 0) send_byte(pick_control(1'b0));
            b = (i == 0 && anomaly) ? B_ANOMALY : body_byte();
            send_byte(b);
            sum = sum + b;
        end
        if (flaw == FLAW_SHORT) return;
        send_byte(B_ETX);
        send_checksum(sum, flaw);
    endtask

    task automatic run_stream(int target);
        int  first;
        int  r;
        int  len;
        int  flaw;
        bit  lead_stx;
        first = live_words;
        while (live_words - first < target) begin
            r = $urandom_range(0, 99);
            if ((tracker.state == ST_IDLE && r < 90) || r < 4) begin
                send_start($urandom_range(0, 99) < 80, $urandom_range(0, 99) < 20);
            end else if (r < 62) begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : $urandom_range(1, 4);
                lead_stx = !(tracker.state == ST_BODY && tracker.body_count == 0) ||
                           $urandom_range(0, 1);
                send_frame(len, flaw, $urandom_range(0, 9) == 0, lead_stx);
            end else if (r < 70) begin
                send_word(mk_word(ACT_TIMEOUT, 8'($urandom_range(0, 255))));
            end else if (r < 82) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (r < 92) begin
                send_byte(pick_control(1'b1));
            end else begin
                send_word(mk_word(ACT_UNDEFINED, 8'($urandom_range(0, 255))));
            end
        end
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_config(index, value);
    endtask

    task automatic configure(logic [7:0] limit, logic [1:0] offset, bit recovery);
        write_reg(CFG_RETRY_LIMIT, limit);
        write_reg(CFG_CMD_OFFSET, {6'd0, offset});
        write_reg(CFG_RECOVERY_EN, {7'd0, recovery});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // body runs past the limit: once with a retry to spare, once to exhaustion
    task automatic send_oversized();
        logic [15:0] sum;
        logic [7:0]  b;
        sum = '0;
        send_start(1'b1, 1'b0);
        send_byte(B_STX);
        repeat (BODY_LIMIT + 1) send_byte(body_byte());
        repeat (3) begin
            b = body_byte();
            send_byte(b);
            sum = sum + b;
        end
        send_byte(B_ETX);
        send_checksum(sum, FLAW_NONE);
        send_start(1'b1, 1'b0);
        send_word(mk_word(ACT_TIMEOUT, 8'h00));
        send_byte(B_STX);
        repeat (BODY_LIMIT + 1) send_byte(body_byte());
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, no idling
        send_byte(8'h41);
        send_word(mk_word(ACT_TIMEOUT, 8'h00));
        send_word(mk_word(ACT_UNDEFINED, 8'hFF));
        send_start(1'b1, 1'b1);
        send_byte(B_ETX);
        send_byte(B_DC2);
        send_byte(B_DC4);
        send_byte(B_ACK);
        send_byte(B_NAK);
        send_byte(8'h41);
        send_word(mk_word(ACT_TIMEOUT, 8'h00));
        send_byte(B_STX);
        send_byte(8'h41);
        send_byte(B_STX);
        send_byte(B_ETX);
        send_checksum(16'h0000, FLAW_NONE);
        send_start(1'b0, 1'b0);
        send_byte(B_ANOMALY);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(B_ETX);
        send_checksum(16'h017E, FLAW_NONE);

        // a run of busy words, then clear the counter
        send_start(1'b1, 1'b1);
        repeat (12) send_byte(B_DC2);
        send_start(1'b1, 1'b1);
        run_stream(120);
        drain();

        configure(8'd1, 2'd2, 1'b1);
        send_idle_pct = 60;
        stall_pct     = 0;
        run_stream(120);
        drain();

        configure(8'd255, 2'd0, 1'b0);
        send_idle_pct = 0;
        stall_pct     = 60;
        run_stream(120);
        drain();

        configure(8'd2, 2'd3, 1'b1);
        send_idle_pct = 14;
        stall_pct     = 14;
        send_oversized();
        run_stream(120);
        drain();

        // zero retries: every start ends the wait at once
        configure(8'd0, 2'd1, 1'b0);
        run_stream(30);
        drain();

        if (tracker.errors == 0 && tracker.pending_responses.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
